/* rtl/core/csem_pkg.sv */
package csem_pkg;

  localparam int unsigned TID_W   = 8;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned CNT_W   = 17;
  localparam int unsigned INIT_W  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_WAIT    = 2'd0,
    CMD_SIGNAL  = 2'd1,
    CMD_TRYWAIT = 2'd2,
    CMD_CLOSE   = 2'd3
  } csem_cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 3'd0,
    ST_WOULD_BLOCK  = 3'd1,
    ST_QUEUED       = 3'd2,
    ST_CLOSED_ERR   = 3'd3,
    ST_WOKEN_GRANT  = 3'd4,
    ST_WOKEN_CLOSED = 3'd5,
    ST_QUEUE_FULL   = 3'd6,
    ST_OVERFLOW     = 3'd7
  } csem_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN,
    S_ACK
  } csem_state_e;

  // queue requests from the sequencer
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             clear;
    logic [TID_W-1:0] push_tid;
  } csem_qctl_t;

  // queue status back to the sequencer
  typedef struct packed {
    logic             empty;
    logic             full;
    logic [TID_W-1:0] head_tid;
  } csem_qstat_t;

  // one result word toward the output register
  typedef struct packed {
    logic             valid;
    logic [TID_W-1:0] tid;
    csem_status_e     status;
    logic             last;
  } csem_res_t;

endpackage

/* rtl/core/csem_queue.sv */
module csem_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  csem_pkg::csem_qctl_t  ctl_i,
  output csem_pkg::csem_qstat_t stat_o
);
  import csem_pkg::*;

  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = FILL_W + 1;

  logic [TID_W-1:0]  mem [DEPTH];
  logic [TID_W-1:0]  rd_q;
  logic [IDX_W-1:0]  head_q, head_d, head_inc, tail;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [SUM_W-1:0]  tail_sum;

  assign head_inc = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
  assign tail_sum = SUM_W'(head_q) + SUM_W'(fill_q);
  assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(tail_sum);

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (ctl_i.clear) begin
      head_d = '0;
      fill_d = '0;
    end else if (ctl_i.pop) begin
      head_d = head_inc;
      fill_d = fill_q - FILL_W'(1);
    end else if (ctl_i.push) begin
      fill_d = fill_q + FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // read tracks next head so oldest waiter is at hand once written
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail] <= ctl_i.push_tid;
    end
    rd_q <= mem[head_d];
  end

  assign stat_o.empty    = (fill_q == '0);
  assign stat_o.full     = (fill_q == FILL_W'(DEPTH));
  assign stat_o.head_tid = rd_q;

endmodule

/* rtl/core/csem_ctrl.sv */
module csem_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  csem_pkg::csem_cmd_e         in_cmd_i,
  input  logic [csem_pkg::TID_W-1:0]  in_tid_i,
  input  logic                        cfg_valid_i,
  input  logic [csem_pkg::INIT_W-1:0] cfg_data_i,
  input  logic                        out_free_i,
  input  csem_pkg::csem_qstat_t       qstat_i,
  output csem_pkg::csem_qctl_t        qctl_o,
  output csem_pkg::csem_res_t         res_o
);
  import csem_pkg::*;

  csem_state_e         state_q, state_d;
  csem_cmd_e           cmd_q;
  logic [TID_W-1:0]    tid_q;
  logic signed [CNT_W-1:0] count_q, count_sum;
  logic                closed_q;
  logic                cnt_step, cnt_inc, cnt_zero, set_closed;
  logic                le_zero, at_max, can_wake;

  // shared count adder
  assign count_sum = count_q + (cnt_inc ? CNT_W'(1) : {CNT_W{1'b1}});

  assign le_zero  = count_q[CNT_W-1] || (count_q == '0);
  assign at_max   = !count_q[CNT_W-1] && (count_q[INIT_W-1:0] == {INIT_W{1'b1}});
  assign can_wake = count_q[CNT_W-1] && !qstat_i.empty;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!closed_q && cmd_q == CMD_CLOSE) begin
          state_d = S_DRAIN;
        end else if (out_free_i) begin
          if (!closed_q && cmd_q == CMD_SIGNAL && !at_max && can_wake) state_d = S_ACK;
          else state_d = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (out_free_i && qstat_i.empty) state_d = S_IDLE;
      end
      S_ACK: begin
        if (out_free_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_o      = '{valid: 1'b0, tid: tid_q, status: ST_OK, last: 1'b1};
    qctl_o     = '{push: 1'b0, pop: 1'b0, clear: cfg_valid_i, push_tid: tid_q};
    cnt_step   = 1'b0;
    cnt_inc    = 1'b0;
    cnt_zero   = 1'b0;
    set_closed = 1'b0;
    unique case (state_q)
      S_IDLE: ;
      S_EXEC: begin
        if (closed_q) begin
          res_o.valid  = out_free_i;
          res_o.status = ST_CLOSED_ERR;
        end else begin
          unique case (cmd_q)
            CMD_WAIT: begin
              res_o.valid = out_free_i;
              if (le_zero && qstat_i.full) begin
                res_o.status = ST_QUEUE_FULL;
              end else begin
                cnt_step     = out_free_i;
                qctl_o.push  = out_free_i && le_zero;
                res_o.status = le_zero ? ST_QUEUED : ST_OK;
              end
            end
            CMD_SIGNAL: begin
              res_o.valid = out_free_i;
              if (at_max) begin
                res_o.status = ST_OVERFLOW;
              end else begin
                cnt_step = out_free_i;
                cnt_inc  = 1'b1;
                if (can_wake) begin
                  qctl_o.pop   = out_free_i;
                  res_o.tid    = qstat_i.head_tid;
                  res_o.status = ST_WOKEN_GRANT;
                  res_o.last   = 1'b0;
                end
              end
            end
            CMD_TRYWAIT: begin
              res_o.valid  = out_free_i;
              cnt_step     = out_free_i && !le_zero;
              res_o.status = le_zero ? ST_WOULD_BLOCK : ST_OK;
            end
            CMD_CLOSE: begin
              set_closed = 1'b1;
              cnt_zero   = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_DRAIN: begin
        res_o.valid = out_free_i;
        if (!qstat_i.empty) begin
          qctl_o.pop   = out_free_i;
          res_o.tid    = qstat_i.head_tid;
          res_o.status = ST_WOKEN_CLOSED;
          res_o.last   = 1'b0;
        end
      end
      S_ACK: begin
        res_o.valid = out_free_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      closed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        count_q  <= signed'({1'b0, cfg_data_i});
        closed_q <= 1'b0;
      end else begin
        if (cnt_zero) count_q <= '0;
        else if (cnt_step) count_q <= count_sum;
        if (set_closed) closed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= in_cmd_i;
      tid_q <= in_tid_i;
    end
  end

endmodule

/* rtl/core/counting_semaphore_waitq_top.sv */
// Counting semaphore with a FIFO wait queue of up to QUEUE_DEPTH blocked thread ids.
// Each input word is a command (tuser) with the requesting thread id (tdata); the
// block answers with one or more result words, the last one flagged by tlast and
// addressed to the requester. The block takes one command at a time: wait, signal
// and trywait answer from EXEC, a signal that wakes a waiter adds a word from ACK,
// and close empties the queue in DRAIN, where the sequencer pops the queue memory
// one waiter per cycle, while the output register has room, through its registered
// read port. Writing initial_count loads the count, reopens a closed semaphore and
// drops any waiters; it is meant to be written while idle.
module counting_semaphore_waitq_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // thread_id
  input  logic [1:0]  s_axis_tuser,   // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // thread_id_res
  output logic [2:0]  m_axis_tuser,   // status
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i      // initial_count
);
  import csem_pkg::*;

  csem_qctl_t       qctl;
  csem_qstat_t      qstat;
  csem_res_t        res;
  logic             out_free;
  logic             out_valid_q;
  logic [TID_W-1:0] out_tid_q;
  csem_status_e     out_status_q;
  logic             out_last_q;

  assign out_free    = !out_valid_q || m_axis_tready;
  assign cfg_ready_o = 1'b1;

  csem_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (qctl),
    .stat_o (qstat)
  );

  csem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (csem_cmd_e'(s_axis_tuser)),
    .in_tid_i    (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_free_i  (out_free),
    .qstat_i     (qstat),
    .qctl_o      (qctl),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      out_tid_q    <= res.tid;
      out_status_q <= res.status;
      out_last_q   <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qctl.push |-> !qstat.full)
    else $error("push into full wait queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qctl.pop |-> !qstat.empty)
    else $error("pop from empty wait queue");

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> out_free)
    else $error("result word lost at output register");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken while busy");

endmodule
